[rtl/core/fcdma_pkg.sv]
// Package for the four-channel DMA controller: payload structs, opcodes,
// count masks. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcdma_pkg;

  typedef enum logic [2:0] {
    OP_WR_SRC  = 3'd0,
    OP_WR_DST  = 3'd1,
    OP_WR_CNT  = 3'd2,
    OP_WR_CTL  = 3'd3,
    OP_STEP    = 3'd4
  } op_t;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_TIMING = 2'd1;
  localparam logic [1:0] ERR_RPT    = 2'd2;
  localparam logic [1:0] ERR_MODE3  = 2'd3;

  localparam logic [21:0] CNT_MASK_MAIN = 22'h1FFFFF;
  localparam logic [21:0] CNT_FULL_MAIN = 22'h200000;
  localparam logic [21:0] CNT_MASK_CH3  = 22'h00FFFF;
  localparam logic [21:0] CNT_FULL_CH3  = 22'h010000;
  localparam logic [21:0] CNT_MASK_LOW  = 22'h003FFF;
  localparam logic [21:0] CNT_FULL_LOW  = 22'h004000;
  localparam logic [15:0] CTL_MASK      = 16'hFFE0;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  channel;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        copy_valid;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        unit_is_word;
    logic [1:0]  active_channel;
    logic        channel_finished;
    logic [3:0]  armed_mask;
    logic [1:0]  error_code;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  ch;
    logic [31:0] data;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/core/four_channel_dma_controller_unit.sv]
// Four-channel DMA controller. Channels: in_ (push/full) takes register
// writes and step commands; out_ (pop/empty) gives one result beat per
// input beat, in order; cfg_ writes cpu_variant (1 = 21-bit counts, 0 = 14/16-bit
// counts), which the user must do only while idle; the block does not enforce it.
// An accepted input beat passes through the front queue, then the back-end
// result buffer, before its result is on the out_ ports and can be popped.
// Throughput: one beat per cycle unless the reader stalls; the back end
// finishes each command with at most one add or subtract per address.
// Reset (rst_n low, synchronous) clears all channel registers, disarms all
// channels and sets cpu_variant to 1.
// When the reader stalls, the two-entry result buffer fills, then the
// two-entry command queue, then full rises; nothing is lost.
// Depends on fcdma_pkg, fcdma_front, fcdma_back.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_dma_controller_unit #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire                   cfg_data,
  input  wire                   push,
  output logic                  full,
  input  fcdma_pkg::in_item_t   in_item,
  output logic                  empty,
  input  wire                   pop,
  output fcdma_pkg::out_item_t  out_item
);
  import fcdma_pkg::*;

  logic cpu_variant_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) cpu_variant_r <= 1'b1;
    else if (cfg_we) cpu_variant_r <= cfg_data;
  end

  fcdma_front u_front (
    .clk(clk), .rst_n(rst_n), .cpu_variant(cpu_variant_r),
    .in_push(push), .in_full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  fcdma_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .out_empty(empty), .out_pop(pop), .out_item(out_item)
  );
endmodule
`default_nettype wire

[rtl/core/fcdma_front.sv]
// Front end: accepts input beats, prepares count values, queues commands.
// Depends on fcdma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcdma_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cpu_variant,
  input  wire                  in_push,
  output logic                 in_full,
  input  fcdma_pkg::in_item_t  in_item,
  output logic                 cmd_valid,
  input  wire                  cmd_take,
  output fcdma_pkg::cmd_t      cmd
);
  import fcdma_pkg::*;

  // two-entry command queue
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok, take_ok;
  cmd_t       cin;
  logic [21:0] cmask, cfull, cm;

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign take_ok   = cmd_take && cmd_valid;
  assign cmd       = q_r[rp_r];

  // count masking done here so the back end sees final values
  always_comb begin
    if (cpu_variant) begin
      cmask = CNT_MASK_MAIN; cfull = CNT_FULL_MAIN;
    end else if (in_item.channel == 2'd3) begin
      cmask = CNT_MASK_CH3;  cfull = CNT_FULL_CH3;
    end else begin
      cmask = CNT_MASK_LOW;  cfull = CNT_FULL_LOW;
    end
    cm = in_item.value[21:0] & cmask;
    cin.op = in_item.operation;
    cin.ch = in_item.channel;
    cin.data = in_item.value;
    if (in_item.operation == OP_WR_CNT) begin
      cin.data = {10'd0, (cm == 22'd0) ? cfull : cm};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cin;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (take_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, take_ok};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !take_ok) |=> in_full) else $error("full dropped");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1 && take_ok && !push_ok) |=> !cmd_valid) else $error("take count");
endmodule
`default_nettype wire

[rtl/core/fcdma_back.sv]
// Back end: channel registers, arbitration, address stepping, result queue.
// Depends on fcdma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcdma_back #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cmd_valid,
  output logic                  cmd_take,
  input  fcdma_pkg::cmd_t       cmd,
  output logic                  out_empty,
  input  wire                   out_pop,
  output fcdma_pkg::out_item_t  out_item
);
  import fcdma_pkg::*;

  logic [31:0] src_r [NUM_CHANNELS];
  logic [31:0] dst_r [NUM_CHANNELS];
  logic [21:0] cnt_r [NUM_CHANNELS];
  logic [15:0] ctl_r [NUM_CHANNELS];
  logic [31:0] lsrc_r [NUM_CHANNELS];
  logic [31:0] ldst_r [NUM_CHANNELS];
  logic [21:0] lrem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] armed_r, armed_nxt;

  // output buffer of two entries so a stalled reader does not block work
  out_item_t ob_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       do_cmd, pop_ok;
  out_item_t  res;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  logic [CW-1:0] sel, wch;
  logic          any, ch_ok;
  logic [15:0]   ctl;
  logic [1:0]    smode, dmode;
  logic [31:0]   unit;
  logic [21:0]   rem_dec;

  assign pop_ok    = out_pop && !out_empty;
  assign out_empty = (ocnt_r == 2'd0);
  assign out_item  = ob_r[orp_r];
  assign cmd_take  = (ocnt_r != 2'd2) || pop_ok;
  assign do_cmd    = cmd_valid && cmd_take;
  assign wch       = cmd.ch[CW-1:0];
  assign ch_ok     = ({30'd0, cmd.ch} < NUM_CHANNELS);

  // lowest armed channel
  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (armed_r[i]) begin
        sel = CW'(i);
        any = 1'b1;
      end
    end
  end

  assign ctl     = ctl_r[sel];
  assign dmode   = ctl[6:5];
  assign smode   = ctl[8:7];
  assign unit    = ctl[10] ? 32'd4 : 32'd2;
  assign rem_dec = lrem_r[sel] - 22'd1;

  // result of the current command
  always_comb begin
    res = '0;
    armed_nxt = armed_r;
    if (cmd.op == OP_WR_CTL && ch_ok) begin
      if (!ctl_r[wch][15] && cmd.data[15]) begin
        if (cmd.data[13:11] == 3'd0) armed_nxt[wch] = 1'b1;
        else res.error_code = ERR_TIMING;
      end
    end else if (cmd.op == OP_STEP && any) begin
      res.active_channel = 2'(sel);
      if (ctl[9] || ctl[14]) res.error_code = ERR_RPT;
      else if (dmode == 2'd3 || smode == 2'd3) res.error_code = ERR_MODE3;
      if (lrem_r[sel] == 22'd0) begin
        armed_nxt[sel] = 1'b0;
        res.channel_finished = 1'b1;
      end else begin
        res.copy_valid = 1'b1;
        res.unit_is_word = ctl[10];
        res.source_address = lsrc_r[sel];
        res.dest_address = ldst_r[sel];
        if (rem_dec == 22'd0) begin
          armed_nxt[sel] = 1'b0;
          res.channel_finished = 1'b1;
        end
      end
    end
    res.armed_mask = 4'(armed_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0; owp_r <= 1'b0; orp_r <= 1'b0; ocnt_r <= 2'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        src_r[i] <= '0; dst_r[i] <= '0; cnt_r[i] <= '0; ctl_r[i] <= '0;
        lsrc_r[i] <= '0; ldst_r[i] <= '0; lrem_r[i] <= '0;
      end
    end else begin
      if (pop_ok) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, do_cmd} - {1'b0, pop_ok};
      if (do_cmd) begin
        ob_r[owp_r] <= res;
        owp_r <= ~owp_r;
        armed_r <= armed_nxt;
        if (ch_ok) begin
          case (cmd.op)
            OP_WR_SRC: src_r[wch] <= cmd.data;
            OP_WR_DST: dst_r[wch] <= cmd.data;
            OP_WR_CNT: cnt_r[wch] <= cmd.data[21:0];
            OP_WR_CTL: begin
              ctl_r[wch] <= cmd.data[15:0] & CTL_MASK;
              if (!ctl_r[wch][15] && cmd.data[15]) begin
                lsrc_r[wch] <= src_r[wch];
                ldst_r[wch] <= dst_r[wch];
                lrem_r[wch] <= cnt_r[wch];
              end
            end
            default: ;
          endcase
        end
        // address stepping for the served channel
        if (cmd.op == OP_STEP && any && lrem_r[sel] != 22'd0) begin
          case (smode)
            2'd0: lsrc_r[sel] <= lsrc_r[sel] + unit;
            2'd1: lsrc_r[sel] <= lsrc_r[sel] - unit;
            default: ;
          endcase
          case (dmode)
            2'd0: ldst_r[sel] <= ldst_r[sel] + unit;
            2'd1: ldst_r[sel] <= ldst_r[sel] - unit;
            default: ;
          endcase
          lrem_r[sel] <= rem_dec;
        end
      end
    end
  end

  a_obuf: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2) else $error("result overflow");
  a_copy_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (do_cmd && res.copy_valid) |-> armed_r[sel]) else $error("copy unarmed");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (do_cmd && res.channel_finished) |=> !armed_r[$past(sel)]) else $error("fin armed");
endmodule
`default_nettype wire

[tb/dma_checker.sv]
// Result checker for the four-channel DMA controller: mirrors channel state,
// predicts each result beat and compares it. Depends on fcdma_pkg.
`timescale 1ns / 1ps
module dma_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  logic                 push,
  input  logic                 full,
  input  fcdma_pkg::in_item_t  in_item,
  input  logic                 empty,
  input  logic                 pop,
  input  fcdma_pkg::out_item_t out_item,
  output int                   fail_count,
  output int                   pending
);
  import fcdma_pkg::*;

  logic [31:0] src_q  [4];
  logic [31:0] dst_q  [4];
  logic [21:0] cnt_q  [4];
  logic [15:0] ctl_q  [4];
  logic [31:0] cur_src[4];
  logic [31:0] cur_dst[4];
  logic [21:0] cur_cnt[4];
  logic [3:0]  armed;
  logic        main_cpu;
  out_item_t   want_q[$];

  assign pending = want_q.size();

  function automatic logic [21:0] masked_count(logic [1:0] ch, logic [31:0] v);
    logic [21:0] m;
    if (main_cpu) begin
      m = v[21:0] & CNT_MASK_MAIN;
      return (m == 0) ? CNT_FULL_MAIN : m;
    end else if (ch == 2'd3) begin
      m = v[21:0] & CNT_MASK_CH3;
      return (m == 0) ? CNT_FULL_CH3 : m;
    end
    m = v[21:0] & CNT_MASK_LOW;
    return (m == 0) ? CNT_FULL_LOW : m;
  endfunction

  function automatic logic [31:0] next_addr(logic [31:0] a, logic [1:0] mode,
                                            logic [31:0] unit);
    if (mode == 2'd0) return a + unit;
    if (mode == 2'd1) return a - unit;
    return a;
  endfunction

  // Apply one input beat to the mirror and return the result it causes
  function automatic out_item_t predict_dma(in_item_t it);
    out_item_t r;
    logic [15:0] old, c;
    logic [1:0] dm, sm;
    int i;
    logic [31:0] unit;
    r = '0;
    case (it.operation)
      OP_WR_SRC: src_q[it.channel] = it.value;
      OP_WR_DST: dst_q[it.channel] = it.value;
      OP_WR_CNT: cnt_q[it.channel] = masked_count(it.channel, it.value);
      OP_WR_CTL: begin
        old = ctl_q[it.channel];
        ctl_q[it.channel] = it.value[15:0] & CTL_MASK;
        if (!old[15] && it.value[15]) begin
          cur_src[it.channel] = src_q[it.channel];
          cur_dst[it.channel] = dst_q[it.channel];
          cur_cnt[it.channel] = cnt_q[it.channel];
          if (ctl_q[it.channel][13:11] == 0) armed[it.channel] = 1'b1;
          else r.error_code = ERR_TIMING;
        end
      end
      OP_STEP: begin
        i = 0;
        while (i < 4 && !armed[i]) i++;
        if (i < 4) begin
          c = ctl_q[i];
          dm = c[6:5];
          sm = c[8:7];
          r.active_channel = i[1:0];
          if (c[9] || c[14]) r.error_code = ERR_RPT;
          else if (dm == 2'd3 || sm == 2'd3) r.error_code = ERR_MODE3;
          if (cur_cnt[i] == 0) begin
            armed[i] = 1'b0;
            r.channel_finished = 1'b1;
          end else begin
            r.unit_is_word = c[10];
            unit = c[10] ? 32'd4 : 32'd2;
            r.copy_valid = 1'b1;
            r.source_address = cur_src[i];
            r.dest_address = cur_dst[i];
            cur_src[i] = next_addr(cur_src[i], sm, unit);
            cur_dst[i] = next_addr(cur_dst[i], dm, unit);
            cur_cnt[i] = cur_cnt[i] - 22'd1;
            if (cur_cnt[i] == 0) begin
              armed[i] = 1'b0;
              r.channel_finished = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.armed_mask = armed;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t checker: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        src_q[k] = '0; dst_q[k] = '0; cnt_q[k] = '0; ctl_q[k] = '0;
        cur_src[k] = '0; cur_dst[k] = '0; cur_cnt[k] = '0;
      end
      armed = '0;
      main_cpu = 1'b1;
      fail_count = 0;
      want_q.delete();
    end else begin
      if (cfg_we) main_cpu = cfg_data;
      // result side first; a new expectation cannot come out this cycle
      if (pop && !empty) begin
        if (want_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          w = want_q.pop_front();
          if (out_item.copy_valid !== w.copy_valid)
            report_mismatch("copy_valid", out_item.copy_valid, w.copy_valid);
          if (out_item.source_address !== w.source_address)
            report_mismatch("source_address", out_item.source_address, w.source_address);
          if (out_item.dest_address !== w.dest_address)
            report_mismatch("dest_address", out_item.dest_address, w.dest_address);
          if (out_item.unit_is_word !== w.unit_is_word)
            report_mismatch("unit_is_word", out_item.unit_is_word, w.unit_is_word);
          if (out_item.active_channel !== w.active_channel)
            report_mismatch("active_channel", out_item.active_channel, w.active_channel);
          if (out_item.channel_finished !== w.channel_finished)
            report_mismatch("channel_finished", out_item.channel_finished,
                            w.channel_finished);
          if (out_item.armed_mask !== w.armed_mask)
            report_mismatch("armed_mask", out_item.armed_mask, w.armed_mask);
          if (out_item.error_code !== w.error_code)
            report_mismatch("error_code", out_item.error_code, w.error_code);
        end
      end
      if (push && !full) want_q.push_back(predict_dma(in_item));
    end
  end
endmodule

[tb/tb_top.sv]
// Testbench top for four_channel_dma_controller_unit: drives register writes
// and steps in bursts, stalls the reader. Depends on fcdma_pkg, dma_checker.
`timescale 1ns / 1ps
module tb_top;
  import fcdma_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  in_item_t in_item = '0;
  out_item_t out_item;
  int fail_count, pending;
  int idle_cycles = 0;
  bit random_pop = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  four_channel_dma_controller_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  dma_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item), .empty(empty), .pop(pop),
    .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  // Reader: stalls at random, with stretches of always-ready
  always @(negedge clk) begin
    if (!random_pop) pop <= 1'b1;
    else pop <= ($urandom_range(0, 3) != 0) || ($time / 20000) % 3 == 0;
  end

  // Watchdog on accepted beats
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Send one beat, then sometimes a gap; full is stable in the low phase
  task automatic send_beat(op_t op, logic [1:0] ch, logic [31:0] val);
    logic was_full;
    push <= 1'b1;
    in_item <= '{operation: op, channel: ch, value: val};
    was_full = full;
    @(negedge clk);
    while (was_full) begin
      was_full = full;
      @(negedge clk);
    end
    if ($urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_all();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_variant(logic v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Program a channel and start it with the given control halfword
  task automatic program_channel(logic [1:0] ch, logic [31:0] cnt, logic [15:0] ctl);
    send_beat(OP_WR_SRC, ch, $urandom);
    send_beat(OP_WR_DST, ch, $urandom);
    send_beat(OP_WR_CNT, ch, cnt);
    send_beat(OP_WR_CTL, ch, 32'h0);
    send_beat(OP_WR_CTL, ch, {16'($urandom_range(0, 65535)), ctl});
  endtask

  function automatic logic [15:0] rand_ctl();
    logic [15:0] c;
    c = 16'($urandom);
    c[15] = 1'b1;
    if ($urandom_range(0, 3) != 0) begin
      c[13:11] = 3'd0;
      c[14] = 1'b0;
      c[9] = 1'b0;
    end
    return c;
  endfunction

  initial begin
    int n;
    op_t op;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes and special cases
    program_channel(2'd0, 32'd2, 16'h8000);
    send_beat(OP_STEP, 2'd0, 32'd0);
    send_beat(OP_STEP, 2'd0, 32'd0);
    send_beat(OP_STEP, 2'd0, 32'd0);               // nothing armed
    program_channel(2'd1, 32'hFFE00000, 16'hFFFF); // zero count, repeat, timing
    program_channel(2'd2, 32'd1, 16'h85E0);        // mode 3 both sides, word
    send_beat(OP_WR_CTL, 2'd2, 32'h8000);          // enable already set
    send_beat(OP_STEP, 2'd0, 32'hFFFFFFFF);
    program_channel(2'd3, 32'd3, 16'h8440);        // fixed dest, increment src
    send_beat(OP_WR_CTL, 2'd3, 32'h0);             // clearing enable keeps arm
    repeat (3) send_beat(OP_STEP, 2'd0, 32'd0);
    send_beat(op_t'(3'd5), 2'd1, 32'h12345678);
    send_beat(op_t'(3'd7), 2'd3, 32'hFFFFFFFF);
    drain_all();

    // Random phases over both processor variants
    for (int phase = 0; phase < 4; phase++) begin
      set_variant(phase[0]);
      random_pop = (phase != 2);
      n = 0;
      while (n < 118) begin
        if ($urandom_range(0, 9) < 3) begin
          program_channel(2'($urandom_range(0, 3)),
                          ($urandom_range(0, 7) == 0) ? $urandom :
                          ($urandom_range(0, 9) == 0 ? 32'h0 : $urandom_range(1, 6)),
                          rand_ctl());
          n += 5;
        end else if ($urandom_range(0, 9) < 8) begin
          send_beat(OP_STEP, 2'($urandom), $urandom);
          n++;
        end else begin
          op = op_t'(3'($urandom_range(0, 7)));
          send_beat(op, 2'($urandom), $urandom);
          n++;
        end
      end
      drain_all();
    end

    if (fail_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/fcdma_pkg.sv
rtl/core/fcdma_front.sv
rtl/core/fcdma_back.sv
rtl/core/four_channel_dma_controller_unit.sv
tb/dma_checker.sv
tb/tb_top.sv
